// ===== src/tilt_angle_averager_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Tilt angle averager assertion macros
// Shared concurrent check forms for the averager RTL.
// ----------------------------------------------------------------------------
`ifndef TILT_ANGLE_AVERAGER_UNIT_DEFINES_SVH
`define TILT_ANGLE_AVERAGER_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define TAV_ASSERT_IMPLY(label, ck, rn, cond, expr) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (expr)) \
        else $error("tilt averager check failed");

// Next-cycle implication, held off during reset.
`define TAV_ASSERT_NEXT(label, ck, rn, cond, expr) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (expr)) \
        else $error("tilt averager sequence check failed");

`endif

// ===== src/tav_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt angle averager package
// Widths, CORDIC arctangent table and status types shared by all modules.
// ----------------------------------------------------------------------------
package tav_pkg;

    localparam int ACC_W        = 16;
    localparam int ANGLE_W      = 16;
    localparam int SUM_W        = 22;
    localparam int LIMIT_W      = 15;
    localparam int CORDIC_STEPS = 20;
    localparam int ROOT_STEPS   = 24;
    localparam int ATAN_W       = 22;
    localparam int ZACC_W       = 24;
    localparam int RIGHT_ANGLE  = 11520;
    localparam int LIMIT_RESET  = 3840;

    typedef struct packed {
        logic                      done;
        logic signed [ANGLE_W-1:0] angle;
    } tilt_status_t;

    typedef struct packed {
        logic                      done;
        logic signed [ANGLE_W-1:0] mean;
    } mean_status_t;

    // atan(2^-i) in 2^-15 degree
    function automatic logic signed [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ATAN_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 22'sd1474560;
                5'd1:    val = 22'sd870484;
                5'd2:    val = 22'sd459940;
                5'd3:    val = 22'sd233473;
                5'd4:    val = 22'sd117189;
                5'd5:    val = 22'sd58652;
                5'd6:    val = 22'sd29333;
                5'd7:    val = 22'sd14667;
                5'd8:    val = 22'sd7334;
                5'd9:    val = 22'sd3667;
                5'd10:   val = 22'sd1833;
                5'd11:   val = 22'sd917;
                5'd12:   val = 22'sd458;
                5'd13:   val = 22'sd229;
                5'd14:   val = 22'sd115;
                5'd15:   val = 22'sd57;
                5'd16:   val = 22'sd29;
                5'd17:   val = 22'sd14;
                5'd18:   val = 22'sd7;
                5'd19:   val = 22'sd4;
                default: val = 22'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== src/tav_if.sv =====
// ----------------------------------------------------------------------------
// Tilt angle averager channels
// Valid/ready channels for accelerometer samples and averaged results.
// ----------------------------------------------------------------------------
interface tav_in_if;
    import tav_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;
    logic                     calibrate;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output calibrate, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input calibrate, output ready);
endinterface

interface tav_out_if;
    import tav_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ANGLE_W-1:0]  mean_pitch;
    logic signed [ANGLE_W-1:0]  mean_roll;
    logic                       over_limit;
    logic                       led_level;

    modport source (output valid, output mean_pitch, output mean_roll,
                    output over_limit, output led_level, input ready);
    modport sink   (input valid, input mean_pitch, input mean_roll,
                    input over_limit, input led_level, output ready);
endinterface

// ===== src/tilt_angle_averager_unit.sv =====
// Flow: square, root, CORDIC and round in the angle units, then hand-off, window
//   update, mean division and output load, from sample accept to result valid.
// Samples: a new one is taken only once the last is through, set by the serial root
//   and CORDIC loops followed by the serial divider; a calibration sample skips the divider.
// Reset: windows read as zero through per-slot valid bits, sums, offsets, LED
//   and slot clear at once; the limit register returns to 30 degrees.
// ----------------------------------------------------------------------------
// Tilt angle averager
// Pitch and roll from a three-axis sample, offset-corrected and averaged over
// a sliding window, with an over-limit flag and an LED that toggles on it.
// ----------------------------------------------------------------------------
`include "tilt_angle_averager_unit_defines.svh"

module tilt_angle_averager_unit #(
    parameter int WINDOW_LEN = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tav_in_if.sink                        in_ch,
    tav_out_if.source                     out_ch,
    input  logic                          cfg_wr_en,
    input  logic [tav_pkg::LIMIT_W-1:0]   cfg_wr_data
);
    import tav_pkg::*;

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int LIM_W  = LIMIT_W + $clog2(WINDOW_LEN + 1);
    localparam int CMP_W  = (LIM_W > SUM_W) ? LIM_W : SUM_W;

    typedef enum logic [2:0] {S_IDLE, S_TILT, S_UPDATE, S_DIV, S_EMIT} state_t;

    // control and state
    state_t                     state_reg;
    logic                       cal_reg;
    logic [LIMIT_W-1:0]         limit_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic signed [SUM_W-1:0]    psum_reg;
    logic signed [SUM_W-1:0]    rsum_reg;
    logic signed [ANGLE_W-1:0]  poff_reg;
    logic signed [ANGLE_W-1:0]  roff_reg;
    logic                       led_reg;
    logic [WINDOW_LEN-1:0]      valid_reg;

    // window stores and their registered read data
    logic signed [ANGLE_W-1:0]  p_mem [WINDOW_LEN];
    logic signed [ANGLE_W-1:0]  r_mem [WINDOW_LEN];
    logic signed [ANGLE_W-1:0]  p_rd_reg;
    logic signed [ANGLE_W-1:0]  r_rd_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [ANGLE_W-1:0]  out_pitch_reg;
    logic signed [ANGLE_W-1:0]  out_roll_reg;
    logic                       out_over_reg;
    logic                       out_led_reg;

    tilt_status_t               p_tilt_st;
    tilt_status_t               r_tilt_st;
    mean_status_t               p_div_st;
    mean_status_t               r_div_st;

    logic                       accept;
    logic                       emit;
    logic signed [ACC_W:0]      pitch_opp;
    logic signed [ACC_W:0]      roll_opp;
    logic signed [ANGLE_W-1:0]  p_corr;
    logic signed [ANGLE_W-1:0]  r_corr;
    logic signed [ANGLE_W-1:0]  p_old;
    logic signed [ANGLE_W-1:0]  r_old;
    logic signed [SUM_W-1:0]    psum_next;
    logic signed [SUM_W-1:0]    rsum_next;
    logic [SUM_W-1:0]           p_mag;
    logic [SUM_W-1:0]           r_mag;
    logic [LIM_W-1:0]           lim_scaled;
    logic                       over;
    logic [SLOT_W-1:0]          slot_next;

    // Accept only when idle; the output register decouples the result side.
    assign accept   = in_ch.valid && in_ch.ready;
    assign emit     = (state_reg == S_EMIT) && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = (state_reg == S_IDLE);

    // pitch = atan2(-z, |x,y|), roll = atan2(x, |y,z|)
    assign pitch_opp = -$signed({in_ch.accel_z[ACC_W-1], in_ch.accel_z});
    assign roll_opp  = $signed({in_ch.accel_x[ACC_W-1], in_ch.accel_x});

    tav_tilt u_pitch_tilt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .opp    (pitch_opp),
        .side_a (in_ch.accel_x),
        .side_b (in_ch.accel_y),
        .status (p_tilt_st)
    );

    tav_tilt u_roll_tilt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .opp    (roll_opp),
        .side_a (in_ch.accel_y),
        .side_b (in_ch.accel_z),
        .status (r_tilt_st)
    );

    always_comb
    begin
        // drop the calibration offsets
        p_corr    = p_tilt_st.angle - poff_reg;
        r_corr    = r_tilt_st.angle - roff_reg;
        // a slot never written reads as zero
        p_old     = valid_reg[slot_reg] ? p_rd_reg : '0;
        r_old     = valid_reg[slot_reg] ? r_rd_reg : '0;
        psum_next = psum_reg + SUM_W'(p_corr) - SUM_W'(p_old);
        rsum_next = rsum_reg + SUM_W'(r_corr) - SUM_W'(r_old);
        slot_next = (int'(slot_reg) >= WINDOW_LEN - 1) ? '0 : slot_reg + SLOT_W'(1);
        // exact limit test: |sum| > limit * N
        p_mag      = psum_reg[SUM_W-1] ? SUM_W'(-psum_reg) : SUM_W'(psum_reg);
        r_mag      = rsum_reg[SUM_W-1] ? SUM_W'(-rsum_reg) : SUM_W'(rsum_reg);
        lim_scaled = LIM_W'(limit_reg) * LIM_W'(WINDOW_LEN);
        over       = (CMP_W'(p_mag) > CMP_W'(lim_scaled)) ||
                     (CMP_W'(r_mag) > CMP_W'(lim_scaled));
    end

    tav_mean_div #(.WINDOW_LEN(WINDOW_LEN)) u_pitch_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_UPDATE),
        .sum    (psum_next),
        .status (p_div_st)
    );

    tav_mean_div #(.WINDOW_LEN(WINDOW_LEN)) u_roll_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_UPDATE),
        .sum    (rsum_next),
        .status (r_div_st)
    );

    // Window stores: write the corrected angles, read the slot to be replaced.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPDATE)
        begin
            p_mem[slot_reg] <= p_corr;
            r_mem[slot_reg] <= r_corr;
        end
        p_rd_reg <= p_mem[slot_reg];
        r_rd_reg <= r_mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cal_reg       <= 1'b0;
            limit_reg     <= LIMIT_W'(LIMIT_RESET);
            slot_reg      <= '0;
            psum_reg      <= '0;
            rsum_reg      <= '0;
            poff_reg      <= '0;
            roff_reg      <= '0;
            led_reg       <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end

            // the consumer took the word and no new one replaces it
            if (out_ch.valid && out_ch.ready && !emit)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cal_reg   <= in_ch.calibrate;
                        state_reg <= S_TILT;
                    end
                end
                S_TILT:
                begin
                    if (p_tilt_st.done && r_tilt_st.done)
                    begin
                        if (cal_reg)
                        begin
                            // hold the new offsets, no result
                            poff_reg  <= p_tilt_st.angle;
                            roff_reg  <= r_tilt_st.angle;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE:
                begin
                    psum_reg            <= psum_next;
                    rsum_reg            <= rsum_next;
                    valid_reg[slot_reg] <= 1'b1;
                    slot_reg            <= slot_next;
                    state_reg           <= S_DIV;
                end
                S_DIV:
                begin
                    if (p_div_st.done && r_div_st.done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pitch_reg <= p_div_st.mean;
                        out_roll_reg  <= r_div_st.mean;
                        out_over_reg  <= over;
                        out_led_reg   <= led_reg ^ over;
                        led_reg       <= led_reg ^ over;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.mean_pitch = out_pitch_reg;
    assign out_ch.mean_roll  = out_roll_reg;
    assign out_ch.over_limit = out_over_reg;
    assign out_ch.led_level  = out_led_reg;

    // An accepted sample always starts the angle units.
    `TAV_ASSERT_NEXT(a_accept_to_tilt, clk, rst_n, accept, state_reg == S_TILT && !p_tilt_st.done)
    // The window slot never leaves the window.
    `TAV_ASSERT_IMPLY(a_slot_in_range, clk, rst_n, 1'b1, int'(slot_reg) < WINDOW_LEN)
    // A window update restarts both dividers.
    `TAV_ASSERT_NEXT(a_update_starts_div, clk, rst_n, state_reg == S_UPDATE, !p_div_st.done && !r_div_st.done)
    // The two dividers run in lockstep.
    `TAV_ASSERT_IMPLY(a_div_lockstep, clk, rst_n, state_reg == S_DIV, p_div_st.done == r_div_st.done)

endmodule

// ===== src/tav_tilt.sv =====
// ----------------------------------------------------------------------------
// Tilt angle unit
// atan2(opp, hypot(a, b)): bit-serial square root, then one CORDIC step a cycle.
// ----------------------------------------------------------------------------
module tav_tilt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tav_pkg::ACC_W:0]    opp,
    input  logic signed [tav_pkg::ACC_W-1:0]  side_a,
    input  logic signed [tav_pkg::ACC_W-1:0]  side_b,
    output tav_pkg::tilt_status_t             status
);
    import tav_pkg::*;

    localparam int SQ_W   = 2 * ACC_W;
    localparam int N_W    = SQ_W + ANGLE_W;
    localparam int ROOT_W = ROOT_STEPS;
    localparam int REM_W  = ROOT_W + 1;
    localparam int CX_W   = ROOT_W + 4;

    typedef enum logic [2:0] {T_IDLE, T_SQB, T_ROOT, T_CORDIC, T_ROUND} tstate_t;

    tstate_t                    state_reg;
    logic [4:0]                 step_reg;
    logic signed [ACC_W:0]      opp_reg;
    logic signed [ACC_W-1:0]    b_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [N_W-1:0]             n_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [ROOT_W-1:0]          root_reg;
    logic signed [CX_W-1:0]     x_reg;
    logic signed [CX_W-1:0]     y_reg;
    logic signed [ZACC_W-1:0]   z_reg;
    logic                       done_reg;
    logic signed [ANGLE_W-1:0]  angle_reg;

    logic signed [ACC_W-1:0]    mul_in;
    logic signed [SQ_W-1:0]     prod;
    logic [REM_W+1:0]           rem_sh;
    logic [REM_W+1:0]           trial;
    logic                       take;
    logic [REM_W-1:0]           rem_next;
    logic [ROOT_W-1:0]          root_next;
    logic signed [CX_W-1:0]     dx;
    logic signed [CX_W-1:0]     dy;
    logic                       y_pos;
    logic signed [ZACC_W-1:0]   z_round;
    logic signed [ANGLE_W-1:0]  r_raw;

    always_comb
    begin
        mul_in    = (state_reg == T_IDLE) ? side_a : b_reg;
        prod      = mul_in * mul_in;
        rem_sh    = {rem_reg, n_reg[N_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        take      = (rem_sh >= trial);
        rem_next  = take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
        root_next = {root_reg[ROOT_W-2:0], take};
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        y_pos     = (y_reg > 0);
        z_round   = z_reg + ZACC_W'(128);
        r_raw     = ANGLE_W'(z_round >>> 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        opp_reg   <= opp;
                        b_reg     <= side_b;
                        sq_reg    <= SQ_W'(prod);
                        done_reg  <= 1'b0;
                        state_reg <= T_SQB;
                    end
                end
                T_SQB:
                begin
                    // seed the root with (a^2 + b^2) * 2^16
                    n_reg     <= {sq_reg + SQ_W'(prod), {ANGLE_W{1'b0}}};
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= T_ROOT;
                end
                T_ROOT:
                begin
                    n_reg    <= {n_reg[N_W-3:0], 2'b00};
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    if (step_reg == 5'(ROOT_STEPS - 1))
                    begin
                        x_reg    <= $signed({4'b0000, root_next});
                        y_reg    <= CX_W'(opp_reg) <<< 8;
                        z_reg    <= '0;
                        step_reg <= '0;
                        if (root_next == '0 && opp_reg == '0)
                        begin
                            angle_reg <= '0;
                            done_reg  <= 1'b1;
                            state_reg <= T_IDLE;
                        end
                        else
                        begin
                            state_reg <= T_CORDIC;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                T_CORDIC:
                begin
                    if (y_pos)
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + ZACC_W'(atan_entry(step_reg));
                    end
                    else
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - ZACC_W'(atan_entry(step_reg));
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= T_ROUND;
                    end
                end
                T_ROUND:
                begin
                    // clamp to a right angle either way
                    if (r_raw > ANGLE_W'(RIGHT_ANGLE))
                        angle_reg <= ANGLE_W'(RIGHT_ANGLE);
                    else if (r_raw < -ANGLE_W'(RIGHT_ANGLE))
                        angle_reg <= -ANGLE_W'(RIGHT_ANGLE);
                    else
                        angle_reg <= r_raw;
                    done_reg  <= 1'b1;
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign status.done  = done_reg;
    assign status.angle = angle_reg;

endmodule

// ===== src/tav_mean_div.sv =====
// ----------------------------------------------------------------------------
// Window mean divider
// Rounded sum / WINDOW_LEN by bit-serial restoring division, one bit a cycle.
// ----------------------------------------------------------------------------
module tav_mean_div #(
    parameter int WINDOW_LEN = 50
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tav_pkg::SUM_W-1:0]  sum,
    output tav_pkg::mean_status_t             status
);
    import tav_pkg::*;

    localparam int NUM_W   = SUM_W + 1;
    localparam int DIV_W   = $clog2(2 * WINDOW_LEN + 1);
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int DIVISOR = 2 * WINDOW_LEN;

    logic                       busy_reg;
    logic                       done_reg;
    logic                       neg_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [DIV_W-1:0]           rem_reg;
    logic signed [ANGLE_W-1:0]  mean_reg;

    logic [SUM_W-1:0]           mag;
    logic [DIV_W:0]             rem_sh;
    logic                       fits;
    logic [NUM_W-1:0]           quot;

    always_comb
    begin
        mag    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        fits   = (rem_sh >= (DIV_W + 1)'(DIVISOR));
        quot   = {num_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            // numerator 2*|sum| + N gives round half away from zero
            num_reg  <= {mag, 1'b0} + NUM_W'(WINDOW_LEN);
            neg_reg  <= sum[SUM_W-1];
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_W'(rem_sh - (DIV_W + 1)'(DIVISOR)) : rem_sh[DIV_W-1:0];
            num_reg <= quot;
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                mean_reg <= neg_reg ? -ANGLE_W'(quot) : ANGLE_W'(quot);
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign status.done = done_reg;
    assign status.mean = mean_reg;

endmodule
